// ----- rtl/mau_pkg.sv -----
`default_nettype none

package mau_pkg;

    localparam int MODULUS_BITS = 31;
    localparam int OPND_W       = 63;
    localparam int OP_W         = 3;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // Counter widths for the operand reducer and the bit-serial multiplier.
    localparam int RCNT_W = $clog2(OPND_W + 1);
    localparam int MCNT_W = $clog2(MODULUS_BITS + 1);

    typedef logic [MODULUS_BITS-1:0] res_t;
    typedef logic [OPND_W-1:0]       opnd_t;

    localparam res_t MOD_RESET = MODULUS_BITS'(64'd1000000007);

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_POW = 3'd3;
    localparam logic [OP_W-1:0] OP_INV = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV = 3'd5;

    localparam logic [PADDR_W-1:0] ADDR_MODULUS = 3'd0;

    typedef struct packed {
        logic start;
        res_t x;
        res_t y;
    } mul_req_t;

endpackage

`default_nettype wire

// ----- rtl/modular_arith_unit.sv -----
// Both operands are first reduced bit-serially, one after the other; add and subtract
// then finish directly, multiply runs one pass of the bit-serial multiplier, and power,
// inverse and divide run one square-and-multiply step per exponent bit up to the highest set bit.
// One word is processed at a time.
// Reset is asynchronous, active low; it sets the modulus to 1000000007 and empties the output.
`default_nettype none

module modular_arith_unit
    import mau_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    req_type,
    input  wire opnd_t              operand_a,
    input  wire opnd_t              operand_b,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output res_t                    residue,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REDA  = 3'd1;
    localparam logic [2:0] S_REDB  = 3'd2;
    localparam logic [2:0] S_DISP  = 3'd3;
    localparam logic [2:0] S_PSTEP = 3'd4;
    localparam logic [2:0] S_PWAIT = 3'd5;
    localparam logic [2:0] S_MULW  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    res_t              mod_reg;
    logic [OP_W-1:0]   op_reg;
    opnd_t             src_reg;
    opnd_t             b_reg;
    opnd_t             exp_reg;
    logic [RCNT_W-1:0] cnt_reg;
    res_t              r_reg;
    res_t              ar_reg;
    res_t              br_reg;
    res_t              acc_reg;
    res_t              sq_reg;
    res_t              res_reg;
    logic              out_valid_reg;
    res_t              residue_reg;

    logic [MODULUS_BITS:0] m_ext;
    logic [MODULUS_BITS:0] shl;
    logic [MODULUS_BITS:0] shl_red;
    res_t                  r_next;
    logic [MODULUS_BITS:0] add_sum;
    logic [MODULUS_BITS:0] add_red;
    logic [MODULUS_BITS:0] sub_diff;
    logic [MODULUS_BITS:0] sub_red;
    opnd_t                 fermat_exp;
    logic                  exp_zero;
    logic                  out_free;

    mul_req_t mul_a_req;
    mul_req_t mul_b_req;
    logic     mul_a_done;
    logic     mul_b_done;
    res_t     mul_a_p;
    res_t     mul_b_p;

    logic cfg_write;

    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_MODULUS);
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_MODULUS) ? PDATA_W'(mod_reg) : '0;

    always_comb
    begin
        m_ext      = {1'b0, mod_reg};
        // Operand reduction: shift one operand bit into the remainder each cycle.
        shl        = {r_reg, src_reg[OPND_W-1]};
        shl_red    = (shl >= m_ext) ? (shl - m_ext) : shl;
        r_next     = shl_red[MODULUS_BITS-1:0];
        add_sum    = {1'b0, ar_reg} + {1'b0, br_reg};
        add_red    = (add_sum >= m_ext) ? (add_sum - m_ext) : add_sum;
        sub_diff   = {1'b0, ar_reg} - {1'b0, br_reg};
        sub_red    = (ar_reg >= br_reg) ? sub_diff : (sub_diff + m_ext);
        fermat_exp = OPND_W'(mod_reg - MODULUS_BITS'(2));
        exp_zero   = (exp_reg == '0);
        out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        mul_a_req.start = 1'b0;
        mul_a_req.x     = ar_reg;
        mul_a_req.y     = br_reg;
        mul_b_req.start = 1'b0;
        mul_b_req.x     = sq_reg;
        mul_b_req.y     = sq_reg;
        case (state_reg)
            S_DISP:
            begin
                mul_a_req.start = (op_reg == OP_MUL);
            end
            S_PSTEP:
            begin
                if (!exp_zero)
                begin
                    mul_a_req.start = 1'b1;
                    mul_a_req.x     = acc_reg;
                    mul_a_req.y     = sq_reg;
                    mul_b_req.start = 1'b1;
                end
                else
                begin
                    // Divide finishes with a times the inverse of b.
                    mul_a_req.start = (op_reg == OP_DIV);
                    mul_a_req.y     = acc_reg;
                end
            end
            default:
            begin
                mul_a_req.start = 1'b0;
            end
        endcase
    end

    mau_mulser u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_a_req),
        .modulus (mod_reg),
        .done    (mul_a_done),
        .product (mul_a_p)
    );

    mau_mulser u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_b_req),
        .modulus (mod_reg),
        .done    (mul_b_done),
        .product (mul_b_p)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((mod_reg < MODULUS_BITS'(2)) || (req_type > OP_DIV))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_REDA;
                    end
                end
            end
            S_REDA:
            begin
                if (cnt_reg == RCNT_W'(1))
                begin
                    state_next = S_REDB;
                end
            end
            S_REDB:
            begin
                if (cnt_reg == RCNT_W'(1))
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (op_reg)
                    OP_ADD:  state_next = S_FIN;
                    OP_SUB:  state_next = S_FIN;
                    OP_MUL:  state_next = S_MULW;
                    default: state_next = S_PSTEP;
                endcase
            end
            S_PSTEP:
            begin
                if (!exp_zero)
                begin
                    state_next = S_PWAIT;
                end
                else if (op_reg == OP_DIV)
                begin
                    state_next = S_MULW;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PWAIT:
            begin
                if (mul_a_done)
                begin
                    state_next = S_PSTEP;
                end
            end
            S_MULW:
            begin
                if (mul_a_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mod_reg       <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                mod_reg <= pwdata[MODULUS_BITS-1:0];
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg  <= req_type;
                src_reg <= operand_a;
                b_reg   <= operand_b;
                cnt_reg <= RCNT_W'(OPND_W);
                r_reg   <= '0;
                res_reg <= '0;
            end
            S_REDA:
            begin
                if (cnt_reg == RCNT_W'(1))
                begin
                    ar_reg  <= r_next;
                    src_reg <= b_reg;
                    r_reg   <= '0;
                    cnt_reg <= RCNT_W'(OPND_W);
                end
                else
                begin
                    src_reg <= {src_reg[OPND_W-2:0], 1'b0};
                    r_reg   <= r_next;
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            S_REDB:
            begin
                src_reg <= {src_reg[OPND_W-2:0], 1'b0};
                r_reg   <= r_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == RCNT_W'(1))
                begin
                    br_reg <= r_next;
                end
            end
            S_DISP:
            begin
                acc_reg <= MODULUS_BITS'(1);
                case (op_reg)
                    OP_ADD:
                    begin
                        res_reg <= add_red[MODULUS_BITS-1:0];
                    end
                    OP_SUB:
                    begin
                        res_reg <= sub_red[MODULUS_BITS-1:0];
                    end
                    OP_POW:
                    begin
                        sq_reg  <= ar_reg;
                        exp_reg <= b_reg;
                    end
                    OP_INV:
                    begin
                        sq_reg  <= ar_reg;
                        exp_reg <= fermat_exp;
                    end
                    default:
                    begin
                        sq_reg  <= br_reg;
                        exp_reg <= fermat_exp;
                    end
                endcase
            end
            S_PSTEP:
            begin
                res_reg <= acc_reg;
            end
            S_PWAIT:
            begin
                if (mul_a_done)
                begin
                    if (exp_reg[0])
                    begin
                        acc_reg <= mul_a_p;
                    end
                    sq_reg  <= mul_b_p;
                    exp_reg <= {1'b0, exp_reg[OPND_W-1:1]};
                end
            end
            S_MULW:
            begin
                if (mul_a_done)
                begin
                    res_reg <= mul_a_p;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    residue_reg <= res_reg;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;

    // A delivered residue is always reduced below a valid modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mod_reg >= MODULUS_BITS'(2))) |-> (residue_reg < mod_reg))
        else $error("residue not reduced below modulus");

    // The square and multiply units run in lockstep during exponentiation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PWAIT) |-> (mul_a_done == mul_b_done))
        else $error("multiplier units out of step");

    // The first multiplier finishes only while the sequencer is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_a_done |-> ((state_reg == S_PWAIT) || (state_reg == S_MULW)))
        else $error("unexpected multiplier completion");

    // An accepted word moves on to operand reduction, or straight to the final state on a bad modulus or request type.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ((state_reg == S_REDA) || (state_reg == S_FIN)))
        else $error("bad dispatch after accept");

endmodule

`default_nettype wire

// ----- rtl/mau_mulser.sv -----
`default_nettype none

module mau_mulser
    import mau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    input  wire res_t     modulus,
    output logic          done,
    output res_t          product
);

    logic              busy_reg;
    logic              done_reg;
    logic [MCNT_W-1:0] cnt_reg;
    res_t              p_reg;
    res_t              x_reg;
    res_t              y_reg;

    logic [MODULUS_BITS:0] dbl;
    logic [MODULUS_BITS:0] dbl_red;
    logic [MODULUS_BITS:0] sum;
    logic [MODULUS_BITS:0] sum_red;
    logic [MODULUS_BITS:0] m_ext;

    // One multiplier bit per cycle, most significant first: p = 2p + y_i*x, kept below m.
    always_comb
    begin
        m_ext   = {1'b0, modulus};
        dbl     = {p_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (y_reg[MODULUS_BITS-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == MCNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MCNT_W'(MODULUS_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            p_reg <= '0;
            x_reg <= req.x;
            y_reg <= req.y;
        end
        else if (busy_reg)
        begin
            p_reg <= sum_red[MODULUS_BITS-1:0];
            y_reg <= {y_reg[MODULUS_BITS-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

`default_nettype wire
